[rtl/tsht_pkg.sv]
// ----------------------------------------------------------------------------
// tsht_pkg
// Types and constants shared by the task state history table files.
// ----------------------------------------------------------------------------
package tsht_pkg;

  localparam int ID_W    = 32;
  localparam int STATE_W = 3;
  localparam int COUNT_W = 32;

  // Operation codes carried in the opcode field of a request beat.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Task state codes that carry a meaning of their own.
  localparam logic [STATE_W-1:0] ST_NONE      = 3'd0;
  localparam logic [STATE_W-1:0] ST_RUNNING   = 3'd1;
  localparam logic [STATE_W-1:0] ST_SUCCEEDED = 3'd2;

  // One stored table entry.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STATE_W-1:0] state;
  } entry_t;

endpackage

[rtl/tsht_req_if.sv]
// ----------------------------------------------------------------------------
// tsht_req_if
// Request channel: one beat is an update or a query for one task id.
// ----------------------------------------------------------------------------
interface tsht_req_if;
  import tsht_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [ID_W-1:0]    task_id;
  logic [STATE_W-1:0] task_state;

  modport source (output valid, opcode, task_id, task_state, input ready);
  modport sink   (input valid, opcode, task_id, task_state, output ready);

endinterface

[rtl/tsht_rsp_if.sv]
// ----------------------------------------------------------------------------
// tsht_rsp_if
// Response channel: one beat per request, with state, hit flag and counters.
// ----------------------------------------------------------------------------
interface tsht_rsp_if;
  import tsht_pkg::*;

  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] state_out;
  logic               found;
  logic [COUNT_W-1:0] executed_count;
  logic [COUNT_W-1:0] succeeded_count;

  modport source (output valid, state_out, found, executed_count, succeeded_count,
                  input ready);
  modport sink   (input valid, state_out, found, executed_count, succeeded_count,
                  output ready);

endinterface

[rtl/task_state_history_table.sv]
// Requests: a beat is taken only in the idle state, so a new request waits until the last
// one has reached the output register, which holds while the receiver is not ready. The
// linear id search does one memory read per stored entry; a hit ends it early, and an
// empty table skips it.
// Reset (rst, synchronous): the table is empty, both counters are zero and no
// response is pending. The memory itself is not cleared; the fill count masks it.
// ----------------------------------------------------------------------------
// task_state_history_table
// Bounded table of task ids and states with oldest-first eviction, plus
// running and succeeded counters. Each request is an update or a query.
// ----------------------------------------------------------------------------
module task_state_history_table #(
  parameter int HISTORY_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  tsht_req_if.sink   req,
  tsht_rsp_if.source rsp
);
  import tsht_pkg::*;

  // Slot address width, and a fill count width that can hold the depth itself.
  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_EMIT
  } fsm_t;

  fsm_t fsm;

  // Table bookkeeping. The oldest slot only moves once the table is full, so
  // until then the valid entries are exactly slots 0 .. entries_used-1, and
  // once full every slot is valid. A scan over 0 .. entries_used-1 therefore
  // touches valid entries only, and no per-entry valid bit is needed.
  logic [CW-1:0]      entries_used;
  logic [AW-1:0]      oldest_slot;
  logic [COUNT_W-1:0] executed_total;
  logic [COUNT_W-1:0] succeeded_total;

  // The request being worked on.
  logic               cur_op;
  logic [ID_W-1:0]    cur_id;
  logic [STATE_W-1:0] cur_state;

  // Search pipeline: a read is issued at scan_addr each cycle and its data is
  // compared in the cycle after, tagged by pend_addr.
  logic [AW-1:0]      scan_addr;
  logic               issue;
  logic               pend;
  logic [AW-1:0]      pend_addr;
  logic               hit;
  logic [AW-1:0]      hit_slot;
  logic [STATE_W-1:0] hit_state;

  // Result of the finished step, waiting for the output register.
  logic [STATE_W-1:0] res_state;
  logic               res_found;

  // Output register.
  logic               rsp_valid;
  logic [STATE_W-1:0] rsp_state;
  logic               rsp_found;
  logic [COUNT_W-1:0] rsp_executed;
  logic [COUNT_W-1:0] rsp_succeeded;

  // Memory ports.
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  entry_t        ram_wr_data;
  logic          ram_rd_en;
  entry_t        ram_rd_data;

  logic match;
  logic last_issue;
  logic table_full;

  tsht_ram #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_addr),
    .rd_data (ram_rd_data)
  );

  assign match      = pend && (ram_rd_data.id == cur_id);
  assign last_issue = ((CW'(scan_addr) + CW'(1)) == entries_used);
  assign table_full = (entries_used == CW'(HISTORY_DEPTH));

  assign ram_rd_en = (fsm == S_SCAN) && issue;

  // An update writes back to the slot where the id was found. A new id goes
  // to the oldest slot when the table is full, evicting that entry, and
  // otherwise to the next free slot, which is entries_used because the
  // oldest slot is still zero.
  always_comb begin
    if (hit) begin
      ram_wr_addr = hit_slot;
    end else if (table_full) begin
      ram_wr_addr = oldest_slot;
    end else begin
      ram_wr_addr = entries_used[AW-1:0];
    end
  end

  assign ram_wr_en         = (fsm == S_RESOLVE) && (cur_op == OP_UPDATE);
  assign ram_wr_data.id    = cur_id;
  assign ram_wr_data.state = cur_state;

  assign req.ready           = (fsm == S_IDLE);
  assign rsp.valid           = rsp_valid;
  assign rsp.state_out       = rsp_state;
  assign rsp.found           = rsp_found;
  assign rsp.executed_count  = rsp_executed;
  assign rsp.succeeded_count = rsp_succeeded;

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm             <= S_IDLE;
      entries_used    <= '0;
      oldest_slot     <= '0;
      executed_total  <= '0;
      succeeded_total <= '0;
      issue           <= 1'b0;
      pend            <= 1'b0;
      hit             <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      // The output register is loaded when the finished step may move in,
      // and freed by a taken response beat otherwise.
      if ((fsm == S_EMIT) && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (fsm)
        S_IDLE: begin
          if (req.valid) begin
            cur_op    <= req.opcode;
            cur_id    <= req.task_id;
            cur_state <= req.task_state;
            scan_addr <= '0;
            hit       <= 1'b0;
            pend      <= 1'b0;
            // An empty table needs no search at all.
            if (entries_used == '0) begin
              issue <= 1'b0;
              fsm   <= S_RESOLVE;
            end else begin
              issue <= 1'b1;
              fsm   <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (match) begin
            // Ids are unique in the table, so the first hit is the only one.
            hit       <= 1'b1;
            hit_slot  <= pend_addr;
            hit_state <= ram_rd_data.state;
            issue     <= 1'b0;
            pend      <= 1'b0;
            fsm       <= S_RESOLVE;
          end else begin
            if (issue) begin
              pend      <= 1'b1;
              pend_addr <= scan_addr;
              if (last_issue) begin
                issue <= 1'b0;
              end else begin
                scan_addr <= scan_addr + AW'(1);
              end
            end else begin
              pend <= 1'b0;
            end
            if (pend && !issue) begin
              // The last stored entry has been compared without a hit.
              fsm <= S_RESOLVE;
            end
          end
        end

        S_RESOLVE: begin
          if (cur_op == OP_UPDATE) begin
            if (!hit) begin
              if (table_full) begin
                if (oldest_slot == AW'(HISTORY_DEPTH - 1)) begin
                  oldest_slot <= '0;
                end else begin
                  oldest_slot <= oldest_slot + AW'(1);
                end
              end else begin
                entries_used <= entries_used + CW'(1);
              end
            end
            if (cur_state == ST_RUNNING) begin
              executed_total <= executed_total + COUNT_W'(1);
            end else if (cur_state == ST_SUCCEEDED) begin
              succeeded_total <= succeeded_total + COUNT_W'(1);
            end
            res_state <= cur_state;
          end else begin
            res_state <= hit ? hit_state : ST_NONE;
          end
          res_found <= hit;
          fsm       <= S_EMIT;
        end

        S_EMIT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_state     <= res_state;
            rsp_found     <= res_found;
            rsp_executed  <= executed_total;
            rsp_succeeded <= succeeded_total;
            fsm           <= S_IDLE;
          end
        end

        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The fill count never passes the depth.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    entries_used <= CW'(HISTORY_DEPTH))
    else $error("fill count exceeds table depth");

  // Eviction only starts once the table is full.
  a_oldest_full: assert property (@(posedge clk) disable iff (rst)
    (oldest_slot != '0) |-> table_full)
    else $error("oldest slot moved before table was full");

  // The fill count grows by one at most, and never shrinks.
  a_used_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (entries_used != $past(entries_used)))
      |-> (entries_used == $past(entries_used) + CW'(1)))
    else $error("fill count changed by other than one");

  // Each step bumps at most one of the two counters.
  a_one_counter: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($stable(executed_total) || $stable(succeeded_total)))
    else $error("both counters changed in one cycle");
`endif

endmodule

[rtl/tsht_ram.sv]
// ----------------------------------------------------------------------------
// tsht_ram
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module tsht_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  tsht_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output tsht_pkg::entry_t rd_data
);
  import tsht_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[verif/task_state_history_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_state_history_table_tb
// Self-checking bench for the task state history table. Requests are driven
// on the request channel. A scoreboard keeps its own copy of the table: the
// ring of slots, the eviction point and both counters. It predicts every
// response beat and checks it field by field, in order. Both sides idle at
// random. The receiver is held off once for a long stretch, and the sender
// pauses until the table has answered everything.
// ----------------------------------------------------------------------------

// One predicted or observed response beat.
typedef struct packed {
  logic [tsht_pkg::STATE_W-1:0] state_out;
  logic                         found;
  logic [tsht_pkg::COUNT_W-1:0] executed;
  logic [tsht_pkg::COUNT_W-1:0] succeeded;
} reply_t;

// Shadow copy of the table. It also holds the queue of replies that are
// still to come back from the block.
class history_scoreboard #(int DEPTH = 64);
  logic [tsht_pkg::ID_W-1:0]    slot_id    [DEPTH];
  logic [tsht_pkg::STATE_W-1:0] slot_state [DEPTH];
  bit                           slot_live  [DEPTH];
  int unsigned                  oldest;
  int unsigned                  used;
  logic [tsht_pkg::COUNT_W-1:0] ran_total;
  logic [tsht_pkg::COUNT_W-1:0] done_total;
  reply_t                       due_replies [$];
  int unsigned                  mismatches;

  function new();
    foreach (slot_live[k]) slot_live[k] = 1'b0;
    oldest      = 0;
    used        = 0;
    ran_total   = '0;
    done_total  = '0;
    mismatches  = 0;
  endfunction

  function int unsigned outstanding();
    return due_replies.size();
  endfunction

  // Applies one accepted request to the shadow table and queues its reply.
  function void note_request(logic op, logic [tsht_pkg::ID_W-1:0] id,
                             logic [tsht_pkg::STATE_W-1:0] st);
    int          hit;
    int unsigned w;
    reply_t      r;
    hit = -1;
    for (int k = 0; k < DEPTH; k++) begin
      if (hit < 0 && slot_live[k] && slot_id[k] == id) hit = k;
    end
    r.found     = (hit >= 0);
    r.state_out = tsht_pkg::ST_NONE;
    if (op == tsht_pkg::OP_UPDATE) begin
      if (hit >= 0) begin
        w = hit;
      end else if (used == DEPTH) begin
        // Full: the oldest slot is reused and becomes the newest.
        w      = oldest;
        oldest = (oldest + 1) % DEPTH;
      end else begin
        w    = (oldest + used) % DEPTH;
        used = used + 1;
      end
      slot_id[w]    = id;
      slot_state[w] = st;
      slot_live[w]  = 1'b1;
      r.state_out   = st;
      if (st == tsht_pkg::ST_RUNNING) ran_total = ran_total + 1;
      else if (st == tsht_pkg::ST_SUCCEEDED) done_total = done_total + 1;
    end else if (hit >= 0) begin
      r.state_out = slot_state[hit];
    end
    r.executed  = ran_total;
    r.succeeded = done_total;
    due_replies.insert(due_replies.size(), r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Checks one response beat against the oldest reply still due.
  function void check_response(reply_t got);
    reply_t want;
    if (due_replies.size() == 0) begin
      $display("%0t: response beat with nothing due, expected none, got 0x%0h",
               $time, got);
      mismatches++;
      return;
    end
    want = due_replies[0];
    due_replies.delete(0);
    compare_field("state_out", 32'(want.state_out), 32'(got.state_out));
    compare_field("found", 32'(want.found), 32'(got.found));
    compare_field("executed_count", want.executed, got.executed);
    compare_field("succeeded_count", want.succeeded, got.succeeded);
  endfunction
endclass

module task_state_history_table_tb;
  import tsht_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int POOL_MAX     = 128;
  // Long enough for the block to fill its output stage and stall the sender.
  localparam int HOLD_CYCLES  = 400;
  // Allow twice the worst case for one request to settle.
  localparam int SETTLE_CYCLES = 2 * (TABLE_DEPTH + 4);
  // Bound for the whole run: around 1300 requests plus idling on both sides.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsht_req_if req_ch ();
  tsht_rsp_if rsp_ch ();

  task_state_history_table #(
    .HISTORY_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  history_scoreboard #(TABLE_DEPTH) board;

  // Idling knobs, changed from phase to phase by the stimulus. A value of
  // zero gives a stretch with no idling on that side.
  int unsigned req_gap_pct   = 0;
  int unsigned rsp_stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_ask      = 1'b0;

  // Ids that the random phases draw from. Odd entries differ from their
  // even neighbour in a single bit, so a partial id compare shows up as a
  // false hit.
  logic [ID_W-1:0] id_pool [POOL_MAX];

  // Watchdog: a hung handshake must not run forever.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("task_state_history_table_tb NOT OK");
      $finish;
    end
  end

  // Receiver side. Each response beat is checked at the edge that accepts
  // it, then ready is chosen for the next edge: a long hold-off when one has
  // been asked for, otherwise random stall bursts.
  initial begin : response_side
    int     stall_left;
    reply_t seen;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.state_out = rsp_ch.state_out;
        seen.found     = rsp_ch.found;
        seen.executed  = rsp_ch.executed_count;
        seen.succeeded = rsp_ch.succeeded_count;
        board.check_response(seen);
      end
      if (hold_ask) begin
        hold_ask   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
        stall_left = $urandom_range(0, 7);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one request beat and waits for it to be taken. The beat is noted
  // in the scoreboard at the accepting edge. After that the sender may go
  // quiet for a random burst; otherwise valid stays high for the next beat.
  task automatic send_request(input logic op, input logic [ID_W-1:0] id,
                              input logic [STATE_W-1:0] st);
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.task_id    <= id;
    req_ch.task_state <= st;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(op, id, st);
    if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Sender pause: nothing is offered until every due reply has come back.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic void refill_pool();
    for (int k = 0; k < POOL_MAX; k += 2) begin
      id_pool[k]     = $urandom();
      id_pool[k + 1] = id_pool[k] ^ (32'd1 << $urandom_range(0, ID_W - 1));
    end
  endfunction

  // Random traffic over the first pool_n ids of the pool. A small pool fits
  // in the table, so most updates and queries hit. A pool larger
  // than the table makes it evict constantly, and fresh ids are mostly
  // misses. A quarter of the time a task is walked through its usual life:
  // running, then succeeded, then queried.
  task automatic run_phase(int n_items, int pool_n, int fresh_pct, int query_pct);
    int               sent;
    logic [ID_W-1:0]  id;
    logic [STATE_W-1:0] st;
    logic             op;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < fresh_pct) id = $urandom();
      else id = id_pool[$urandom_range(0, pool_n - 1)];
      if ($urandom_range(0, 3) == 0) begin
        send_request(OP_UPDATE, id, ST_RUNNING);
        send_request(OP_UPDATE, id, ST_SUCCEEDED);
        send_request(OP_QUERY, id, STATE_W'($urandom()));
        sent += 3;
      end else begin
        op = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_UPDATE;
        case ($urandom_range(0, 9))
          0, 1, 2: st = ST_RUNNING;
          3, 4:    st = ST_SUCCEEDED;
          5:       st = ST_NONE;
          default: st = STATE_W'($urandom_range(0, 7));
        endcase
        send_request(op, id, st);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [ID_W-1:0] odd_ids [5];
    logic [ID_W-1:0] fill_base;

    board = new();
    req_ch.valid      = 1'b0;
    req_ch.opcode     = OP_UPDATE;
    req_ch.task_id    = '0;
    req_ch.task_state = ST_NONE;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. An empty table must miss at both ends of the id range,
    // and the state field of a query must be ignored.
    req_gap_pct   = 20;
    rsp_stall_pct = 20;
    send_request(OP_QUERY, 32'h0000_0000, 3'd7);
    send_request(OP_QUERY, 32'hFFFF_FFFF, 3'd5);
    // An update to state none still inserts the id, so it is found later.
    send_request(OP_UPDATE, 32'h0000_0000, ST_NONE);
    send_request(OP_QUERY, 32'h0000_0000, 3'd7);
    // Running and succeeded each bump their own counter; the second update
    // hits the entry made by the first.
    send_request(OP_UPDATE, 32'hFFFF_FFFF, ST_RUNNING);
    send_request(OP_UPDATE, 32'hFFFF_FFFF, ST_SUCCEEDED);
    send_request(OP_QUERY, 32'hFFFF_FFFF, ST_NONE);
    // The other states are stored as given and leave both counters alone.
    odd_ids = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0000,
                32'hFFFF_FFFE};
    foreach (odd_ids[k]) send_request(OP_UPDATE, odd_ids[k], STATE_W'(k + 3));
    foreach (odd_ids[k]) send_request(OP_QUERY, odd_ids[k], STATE_W'($urandom()));
    send_request(OP_UPDATE, 32'h0000_0000, ST_RUNNING);
    send_request(OP_QUERY, 32'h8000_0001, ST_NONE);

    // Fill the table with fresh ids so that it holds only these. Touching
    // the oldest one must not renew its age, so the next new id evicts it,
    // while the second oldest stays.
    fill_base = $urandom() & 32'hFFFF_FF00;
    for (int k = 0; k < TABLE_DEPTH; k++)
      send_request(OP_UPDATE, fill_base + k, STATE_W'($urandom_range(0, 7)));
    send_request(OP_UPDATE, fill_base, ST_RUNNING);
    send_request(OP_UPDATE, fill_base + TABLE_DEPTH, ST_SUCCEEDED);
    send_request(OP_QUERY, fill_base, ST_NONE);
    send_request(OP_QUERY, fill_base + 1, ST_NONE);

    // Small pool: the pool fits in the table, nearly everything hits.
    refill_pool();
    req_gap_pct   = 30;
    rsp_stall_pct = 30;
    run_phase(300, 24, 3, 40);

    // Let the table answer everything before the next phase.
    drain_responses();

    // Hold the receiver off for a long stretch while requests keep coming
    // back to back, so the block fills up and stops taking beats.
    req_gap_pct   = 0;
    rsp_stall_pct = 0;
    hold_ask      = 1'b1;
    run_phase(24, 24, 0, 50);
    drain_responses();

    // A pool larger than the table: constant eviction, queries of evicted ids.
    refill_pool();
    req_gap_pct   = 15;
    rsp_stall_pct = 40;
    run_phase(400, 90, 5, 35);

    // Half the ids are fresh and random, so many updates insert new ids and many queries miss.
    req_gap_pct   = 40;
    rsp_stall_pct = 10;
    run_phase(250, 40, 50, 45);

    // Final stretch with no idling on either side.
    refill_pool();
    req_gap_pct   = 0;
    rsp_stall_pct = 0;
    run_phase(260, 70, 5, 40);

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("task_state_history_table_tb OK");
    end else begin
      $display("task_state_history_table_tb NOT OK");
    end
    $finish;
  end

endmodule
